### rtl/core/wbps_pkg.sv
package wbps_pkg;

   // Fixed field and register widths
   localparam int DATA_W        = 8;
   localparam int OFFSET_OUT_W  = 32;
   localparam int CSR_DATA_W    = 64;
   localparam int CSR_IDX_W     = 2;
   localparam int MASK_W        = 16;
   localparam int LEN_W         = 5;
   localparam int PAT_REG_BYTES = 16;

   // Register map
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PATTERN_LOW    = 2'd0,
      CSR_PATTERN_HIGH   = 2'd1,
      CSR_WILDCARD_MASK  = 2'd2,
      CSR_PATTERN_LENGTH = 2'd3
   } csr_index_type;

endpackage

### rtl/core/wildcard_byte_pattern_search_top.sv
// Channel   Direction  Ports                          Contents
// req       in         req_tvalid/tready/tdata/tlast  one searched byte, tlast ends range
// rsp       out        rsp_tvalid/tready/tdata/tuser  match offset, tuser = found
// csr       in         csr_wr_en/csr_index/csr_wr_data pattern, mask, length registers
//
// One request per cycle while req_tready is high; its result (if any) is registered
// into the output slot, or the skid slot; the masked window compare is combinational.
// Two result slots (output register plus skid) keep req flowing while rsp stalls;
// req_tready drops only when both slots hold results.
// Synchronous active-high reset; no clearing pass, ready right after reset.
module wildcard_byte_pattern_search_top #(
   parameter int MAX_PATTERN_BYTES = 16,
   parameter int OFFSET_BITS       = 32
) (
   input  logic                               clock,
   input  logic                               reset,
   // request: tdata = data_byte[7:0]; tlast = last_byte
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [wbps_pkg::DATA_W-1:0]        req_tdata,
   input  logic                               req_tlast,
   // result: tdata = match_offset[31:0]; tuser = found
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [wbps_pkg::OFFSET_OUT_W-1:0]  rsp_tdata,
   output logic                               rsp_tuser,
   // configuration write port
   input  logic                               csr_wr_en,
   input  logic [wbps_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [wbps_pkg::CSR_DATA_W-1:0]    csr_wr_data
);
   import wbps_pkg::*;

   localparam int CMP_N  = (MAX_PATTERN_BYTES < PAT_REG_BYTES) ?
                           MAX_PATTERN_BYTES : PAT_REG_BYTES;
   localparam int FILL_W = $clog2(MAX_PATTERN_BYTES + 1);
   localparam int CW     = (FILL_W > LEN_W) ? FILL_W : LEN_W;

   // configuration registers
   logic [CSR_DATA_W-1:0]   pattern_low_ff;
   logic [CSR_DATA_W-1:0]   pattern_high_ff;
   logic [MASK_W-1:0]       wildcard_mask_ff;
   logic [LEN_W-1:0]        pattern_length_ff;

   // search state
   logic [DATA_W-1:0]       window_ff [MAX_PATTERN_BYTES];
   logic [DATA_W-1:0]       window_in [MAX_PATTERN_BYTES];
   logic [FILL_W-1:0]       fill_ff, fill_in, fill_nx;
   logic [OFFSET_BITS-1:0]  count_ff, count_in, count_nx;
   logic                    match_done_ff, match_done_in;

   // result slots
   logic                    out_valid_ff, out_valid_in;
   logic                    out_found_ff, out_found_in;
   logic [OFFSET_OUT_W-1:0] out_offset_ff, out_offset_in;
   logic                    skid_valid_ff, skid_valid_in;
   logic                    skid_found_ff, skid_found_in;
   logic [OFFSET_OUT_W-1:0] skid_offset_ff, skid_offset_in;

   logic [DATA_W-1:0]       win_nx  [MAX_PATTERN_BYTES];
   logic [DATA_W-1:0]       win_sel [CMP_N];
   logic [2*CSR_DATA_W-1:0] pat_all;
   logic [LEN_W-1:0]        len_eff;
   logic [OFFSET_BITS-1:0]  len_m1;
   logic [OFFSET_BITS-1:0]  offset;
   logic                    hit;
   logic                    accept;
   logic                    push;
   logic                    pop;
   logic [OFFSET_OUT_W-1:0] new_offset;

   assign req_tready = !skid_valid_ff;
   assign accept     = req_tvalid && req_tready;
   assign pop        = out_valid_ff && rsp_tready;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_found_ff;
   assign rsp_tdata  = out_offset_ff;

   // effective pattern length: zero acts as one, clamp to compare width
   always_comb begin
      len_eff = pattern_length_ff;
      if (pattern_length_ff == '0) begin
         len_eff = LEN_W'(1);
      end else if (pattern_length_ff > LEN_W'(CMP_N)) begin
         len_eff = LEN_W'(CMP_N);
      end
   end

   assign pat_all = {pattern_high_ff, pattern_low_ff};

   // window after shifting in the request byte, newest at entry 0
   always_comb begin
      win_nx[0] = req_tdata;
      for (int i = 1; i < MAX_PATTERN_BYTES; i++) begin
         win_nx[i] = window_ff[i-1];
      end
   end

   assign fill_nx = (fill_ff < FILL_W'(MAX_PATTERN_BYTES)) ? fill_ff + 1'b1 : fill_ff;

   // pattern byte i lines up with window entry len-1-i
   always_comb begin
      for (int i = 0; i < CMP_N; i++) begin
         win_sel[i] = '0;
         for (int j = 0; j < CMP_N; j++) begin
            if (LEN_W'(i + j + 1) == len_eff) begin
               win_sel[i] = win_nx[j];
            end
         end
      end
   end

   // masked compare over the window
   always_comb begin
      hit = (CW'(fill_nx) >= CW'(len_eff));
      for (int i = 0; i < CMP_N; i++) begin
         if ((LEN_W'(i) < len_eff) && !wildcard_mask_ff[i] &&
             (win_sel[i] != pat_all[DATA_W*i +: DATA_W])) begin
            hit = 1'b0;
         end
      end
   end

   // offset of the first matched byte, from the count before this byte
   assign len_m1   = OFFSET_BITS'(len_eff - 1'b1);
   assign offset   = (count_ff >= len_m1) ? count_ff - len_m1 : '0;
   assign count_nx = (count_ff != '1) ? count_ff + 1'b1 : count_ff;
   assign new_offset = hit ? OFFSET_OUT_W'(offset) : '0;
   assign push     = accept && !match_done_ff && (hit || req_tlast);

   // search state next values
   always_comb begin
      window_in     = window_ff;
      fill_in       = fill_ff;
      count_in      = count_ff;
      match_done_in = match_done_ff;
      if (accept) begin
         if (!match_done_ff) begin
            window_in     = win_nx;
            fill_in       = fill_nx;
            count_in      = count_nx;
            match_done_in = hit;
         end
         if (req_tlast) begin
            fill_in       = '0;
            count_in      = '0;
            match_done_in = 1'b0;
         end
      end
   end

   // result slot next values
   always_comb begin
      out_valid_in   = out_valid_ff;
      out_found_in   = out_found_ff;
      out_offset_in  = out_offset_ff;
      skid_valid_in  = skid_valid_ff;
      skid_found_in  = skid_found_ff;
      skid_offset_in = skid_offset_ff;
      if (pop) begin
         if (skid_valid_ff) begin
            out_found_in  = skid_found_ff;
            out_offset_in = skid_offset_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in  = push;
            out_found_in  = hit;
            out_offset_in = new_offset;
         end
      end else if (!out_valid_ff) begin
         out_valid_in  = push;
         out_found_in  = hit;
         out_offset_in = new_offset;
      end else if (push) begin
         skid_valid_in  = 1'b1;
         skid_found_in  = hit;
         skid_offset_in = new_offset;
      end
   end

   // control and configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_low_ff    <= '0;
         pattern_high_ff   <= '0;
         wildcard_mask_ff  <= '0;
         pattern_length_ff <= LEN_W'(1);
         fill_ff           <= '0;
         count_ff          <= '0;
         match_done_ff     <= 1'b0;
         out_valid_ff      <= 1'b0;
         skid_valid_ff     <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            case (csr_index_type'(csr_index))
               CSR_PATTERN_LOW:    pattern_low_ff    <= csr_wr_data;
               CSR_PATTERN_HIGH:   pattern_high_ff   <= csr_wr_data;
               CSR_WILDCARD_MASK:  wildcard_mask_ff  <= csr_wr_data[MASK_W-1:0];
               CSR_PATTERN_LENGTH: pattern_length_ff <= csr_wr_data[LEN_W-1:0];
               default: ;
            endcase
         end
         fill_ff       <= fill_in;
         count_ff      <= count_in;
         match_done_ff <= match_done_in;
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      window_ff      <= window_in;
      out_found_ff   <= out_found_in;
      out_offset_ff  <= out_offset_in;
      skid_found_ff  <= skid_found_in;
      skid_offset_ff <= skid_offset_in;
   end

   // checks
   a_skid_needs_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid slot full while output slot empty");

   a_notfound_zero: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !out_found_ff) |-> (out_offset_ff == '0))
      else $error("not-found result carries nonzero offset");

   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      (accept && req_tlast) |=> (fill_ff == '0 && count_ff == '0 && !match_done_ff))
      else $error("range state not cleared after last byte");

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_W'(MAX_PATTERN_BYTES))
      else $error("window fill beyond window depth");

   a_done_no_result: assert property (@(posedge clock) disable iff (reset)
      (accept && match_done_ff && !pop && out_valid_ff && !skid_valid_ff)
      |=> !skid_valid_ff)
      else $error("result produced after match already reported");

endmodule
